FILE: rtl/core/json_stream_validator_macros.svh
// assertion macros shared by the checker
`ifndef JSON_STREAM_VALIDATOR_MACROS_SVH
`define JSON_STREAM_VALIDATOR_MACROS_SVH
// implication checked on every edge once out of reset
`define JSV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define JSV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`endif

FILE: rtl/core/jsv_pkg.sv
`timescale 1ns / 1ps
package jsv_pkg;
  localparam int MaxNestingDef = 32;
  localparam int QueueDepth = 2;

  typedef enum logic [4:0] {
    M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_OBJ_KEY, M_COLON, M_AFTER,
    M_STR_VAL, M_ESC_VAL, M_HEX_VAL, M_STR_KEY, M_ESC_KEY, M_HEX_KEY,
    M_LIT_NULL, M_LIT_TRUE, M_LIT_FALSE, M_NUM_MINUS, M_NUM_ZERO, M_NUM_INT,
    M_NUM_DOT, M_NUM_FRAC, M_NUM_E, M_NUM_ESIGN, M_NUM_EXP
  } mode_t;

  // request passed from the parser to the result queue
  typedef struct packed {
    logic valid;
  } result_t;

  // expected literal character by kind and position
  function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (which)
      2'd0: ch = (pos == 3'd1) ? "u" : (pos == 3'd2) ? "l" : (pos == 3'd3) ? "l" : 8'h00;
      2'd1: ch = (pos == 3'd1) ? "r" : (pos == 3'd2) ? "u" : (pos == 3'd3) ? "e" : 8'h00;
      2'd2: ch = (pos == 3'd1) ? "a" : (pos == 3'd2) ? "l" : (pos == 3'd3) ? "s" :
                 (pos == 3'd4) ? "e" : 8'h00;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction
endpackage

FILE: rtl/core/jsv_parser.sv
`timescale 1ns / 1ps
module jsv_parser #(
  parameter int MAX_NESTING = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        data_byte,
  input  logic              end_of_doc,
  output logic              res_vld,
  output jsv_pkg::result_t  res
);
  import jsv_pkg::*;
  localparam int LW = $clog2(MAX_NESTING + 1);
  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  mode_t mode_r, mode_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [2:0] lit_r, lit_nxt, hex_r, hex_nxt;
  logic err_r, err_nxt;
  logic [MAX_NESTING-1:0] stk_r;
  logic push, push_obj;
  logic [7:0] c;
  logic ws, dig, hx, top, num_acc;
  logic [AW-1:0] top_idx;

  assign c = data_byte;
  assign ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  assign dig = (c >= "0" && c <= "9");
  assign hx = dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  assign top_idx = AW'(lvl_r - LW'(1));
  assign top = stk_r[top_idx];

  // next grammar position for one byte
  always_comb begin
    logic startv, afterv, closec;
    logic [1:0] which;
    logic [2:0] llen;
    mode_t m;
    startv = 1'b0;
    afterv = 1'b0;
    closec = 1'b0;
    m = mode_r;
    which = 2'((m == M_LIT_NULL) ? 0 : (m == M_LIT_TRUE) ? 1 : 2);
    llen = (which == 2'd2) ? 3'd5 : 3'd4;
    mode_nxt = mode_r;
    lvl_nxt = lvl_r;
    lit_nxt = lit_r;
    hex_nxt = hex_r;
    err_nxt = err_r;
    push = 1'b0;
    push_obj = 1'b0;
    if (!err_r) begin
      unique case (mode_r)
        M_VALUE: startv = 1'b1;
        M_ARR_FIRST: begin
          if (c == "]") closec = 1'b1;
          else startv = 1'b1;
        end
        M_OBJ_FIRST: begin
          if (ws) begin
          end else if (c == "}") closec = 1'b1;
          else if (c == "\"") mode_nxt = M_STR_KEY;
          else err_nxt = 1'b1;
        end
        M_OBJ_KEY: begin
          if (!ws) begin
            if (c == "\"") mode_nxt = M_STR_KEY;
            else err_nxt = 1'b1;
          end
        end
        M_COLON: begin
          if (!ws) begin
            if (c == ":") mode_nxt = M_VALUE;
            else err_nxt = 1'b1;
          end
        end
        M_AFTER: afterv = 1'b1;
        M_STR_VAL, M_STR_KEY: begin
          if (c == "\"") mode_nxt = (mode_r == M_STR_KEY) ? M_COLON : M_AFTER;
          else if (c < 8'h20) err_nxt = 1'b1;
          else if (c == "\\") mode_nxt = (mode_r == M_STR_KEY) ? M_ESC_KEY : M_ESC_VAL;
        end
        M_ESC_VAL, M_ESC_KEY: begin
          if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" || c == "n" ||
              c == "r" || c == "t")
            mode_nxt = (mode_r == M_ESC_KEY) ? M_STR_KEY : M_STR_VAL;
          else if (c == "u") begin
            hex_nxt = 3'd0;
            mode_nxt = (mode_r == M_ESC_KEY) ? M_HEX_KEY : M_HEX_VAL;
          end else err_nxt = 1'b1;
        end
        M_HEX_VAL, M_HEX_KEY: begin
          if (!hx) err_nxt = 1'b1;
          else if (hex_r >= 3'd3) begin
            hex_nxt = 3'd0;
            mode_nxt = (mode_r == M_HEX_KEY) ? M_STR_KEY : M_STR_VAL;
          end else hex_nxt = hex_r + 3'd1;
        end
        M_LIT_NULL, M_LIT_TRUE, M_LIT_FALSE: begin
          if (lit_r >= llen || c != lit_char(which, lit_r)) err_nxt = 1'b1;
          else if (lit_r + 3'd1 >= llen) begin
            lit_nxt = 3'd0;
            mode_nxt = M_AFTER;
          end else lit_nxt = lit_r + 3'd1;
        end
        M_NUM_MINUS: begin
          if (c == "0") mode_nxt = M_NUM_ZERO;
          else if (dig) mode_nxt = M_NUM_INT;
          else err_nxt = 1'b1;
        end
        M_NUM_ZERO, M_NUM_INT: begin
          if (mode_r == M_NUM_INT && dig) begin
          end else if (c == ".") mode_nxt = M_NUM_DOT;
          else if (c == "e" || c == "E") mode_nxt = M_NUM_E;
          else afterv = 1'b1;
        end
        M_NUM_DOT: begin
          if (dig) mode_nxt = M_NUM_FRAC;
          else err_nxt = 1'b1;
        end
        M_NUM_FRAC: begin
          if (dig) begin
          end else if (c == "e" || c == "E") mode_nxt = M_NUM_E;
          else afterv = 1'b1;
        end
        M_NUM_E: begin
          if (c == "+" || c == "-") mode_nxt = M_NUM_ESIGN;
          else if (dig) mode_nxt = M_NUM_EXP;
          else err_nxt = 1'b1;
        end
        M_NUM_ESIGN: begin
          if (dig) mode_nxt = M_NUM_EXP;
          else err_nxt = 1'b1;
        end
        M_NUM_EXP: begin
          if (!dig) afterv = 1'b1;
        end
        default: err_nxt = 1'b1;
      endcase
      // value start
      if (startv && !ws) begin
        if (c == "\"") mode_nxt = M_STR_VAL;
        else if (c == "{" || c == "[") begin
          if (lvl_r >= LW'(MAX_NESTING)) err_nxt = 1'b1;
          else begin
            push = 1'b1;
            push_obj = (c == "{");
            lvl_nxt = lvl_r + LW'(1);
            mode_nxt = (c == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
          end
        end else if (c == "n") begin
          mode_nxt = M_LIT_NULL; lit_nxt = 3'd1;
        end else if (c == "t") begin
          mode_nxt = M_LIT_TRUE; lit_nxt = 3'd1;
        end else if (c == "f") begin
          mode_nxt = M_LIT_FALSE; lit_nxt = 3'd1;
        end else if (c == "-") mode_nxt = M_NUM_MINUS;
        else if (c == "0") mode_nxt = M_NUM_ZERO;
        else if (dig) mode_nxt = M_NUM_INT;
        else err_nxt = 1'b1;
      end
      // position after a value
      if (afterv) begin
        mode_nxt = M_AFTER;
        if (!ws) begin
          if (lvl_r == '0) err_nxt = 1'b1;
          else if (c == ",") mode_nxt = top ? M_OBJ_KEY : M_VALUE;
          else if ((c == "]" && !top) || (c == "}" && top)) closec = 1'b1;
          else err_nxt = 1'b1;
        end
      end
      if (closec) begin
        if (lvl_r != '0) lvl_nxt = lvl_r - LW'(1);
        mode_nxt = M_AFTER;
      end
    end
    num_acc = (mode_nxt == M_NUM_ZERO) || (mode_nxt == M_NUM_INT) ||
              (mode_nxt == M_NUM_FRAC) || (mode_nxt == M_NUM_EXP);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_VALUE;
      lvl_r <= '0;
      lit_r <= '0;
      hex_r <= '0;
      err_r <= 1'b0;
    end else if (byte_vld) begin
      if (end_of_doc) begin
        mode_r <= M_VALUE;
        lvl_r <= '0;
        lit_r <= '0;
        hex_r <= '0;
        err_r <= 1'b0;
      end else begin
        mode_r <= mode_nxt;
        lvl_r <= lvl_nxt;
        lit_r <= lit_nxt;
        hex_r <= hex_nxt;
        err_r <= err_nxt;
      end
    end
  end

  // container kind stack
  always_ff @(posedge clk) begin
    if (byte_vld && push) stk_r[AW'(lvl_r)] <= push_obj;
  end

  assign res_vld = byte_vld && end_of_doc;
  assign res.valid = !err_nxt && (lvl_nxt == '0) && (mode_nxt == M_AFTER || num_acc);
endmodule

FILE: rtl/core/jsv_result_queue.sv
`timescale 1ns / 1ps
module jsv_result_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  jsv_pkg::result_t wr_data,
  output logic             full,
  output logic             empty,
  input  logic             rd_en,
  output jsv_pkg::result_t rd_data
);
  import jsv_pkg::*;
  result_t mem_r [QueueDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'(QueueDepth));
  assign empty = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule

FILE: rtl/core/json_stream_validator.sv
`timescale 1ns / 1ps
// json_stream_validator: streaming JSON syntax checker
// Input: push a document byte on in_data_byte with in_end_of_doc on the final
// byte; a byte is taken when push is high and full is low.
// Output: one request per document on out_doc_valid, read as a queue: the
// result is shown while empty is low and taken on pop.
// Throughput: one byte per clock while full is low; parser state is registered.
// The result appears in the cycle after the final byte is taken.
// A two-entry result queue separates parser and receiver; full rises only
// when two results wait untaken, so a stalled receiver holds input only then.
// Reset (rst_n low, synchronous) returns the parser to the top-level start
// and empties the queue. After each final byte the parser resets itself for
// the next document.
module json_stream_validator #(
  parameter int MAX_NESTING = jsv_pkg::MaxNestingDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_doc,
  output logic       empty,
  input  logic       pop,
  output logic       out_doc_valid
);
  import jsv_pkg::*;
  logic acc, res_vld;
  result_t res, q_out;

  assign acc = push && !full;

  // front: byte parser
  jsv_parser #(.MAX_NESTING(MAX_NESTING)) u_parser (
    .clk, .rst_n, .byte_vld(acc), .data_byte(in_data_byte),
    .end_of_doc(in_end_of_doc), .res_vld, .res
  );

  // back: result queue
  jsv_result_queue u_queue (
    .clk, .rst_n, .wr_en(res_vld), .wr_data(res), .full, .empty,
    .rd_en(pop && !empty), .rd_data(q_out)
  );

  assign out_doc_valid = q_out.valid;
endmodule

FILE: rtl/core/jsv_checker.sv
`timescale 1ns / 1ps
`include "json_stream_validator_macros.svh"
module jsv_checker (
  input logic clk,
  input logic rst_n,
  input logic push,
  input logic full,
  input logic in_end_of_doc,
  input logic empty,
  input logic pop
);
  // a final byte always yields a visible result next cycle
  `JSV_ASSERT_NXT(a_res_after_end, clk, rst_n, push && !full && in_end_of_doc, !empty)
  // with no final byte and no result pending, nothing shows
  `JSV_ASSERT_NXT(a_no_spurious, clk, rst_n, empty && !(push && !full && in_end_of_doc), empty)
  // full only with a result waiting
  `JSV_ASSERT_IMP(a_full_not_empty, clk, rst_n, full, !empty)
  // a pop while full frees space
  `JSV_ASSERT_NXT(a_pop_frees, clk, rst_n, full && pop, !full)
endmodule

bind json_stream_validator jsv_checker u_jsv_checker (
  .clk, .rst_n, .push, .full, .in_end_of_doc, .empty, .pop
);

FILE: test/json_stream_validator_tb.sv
`timescale 1ns / 1ps
module json_stream_validator_tb;
  import jsv_pkg::*;

  localparam int MaxDepth = MaxNestingDef;
  localparam int CycleLimit = 400000;
  localparam int ByteTarget = 450;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef logic [7:0] byte_q_t[$];

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_data_byte;
  logic       in_end_of_doc;
  logic       empty;
  logic       pop;
  logic       out_doc_valid;

  byte_req_t  pending_q[$];
  logic       valid_expect_q[$];
  int         n_accepted;
  int         n_total;
  int         n_results;
  int         n_errors;
  int         cycle_cnt;

  // parser shadow state
  mode_t      pm;
  logic       stk[MaxDepth];
  int         lvl;
  int         lpos;
  int         hexn;
  logic       err;

  json_stream_validator i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_data_byte (in_data_byte),
    .in_end_of_doc(in_end_of_doc),
    .empty        (empty),
    .pop          (pop),
    .out_doc_valid(out_doc_valid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- syntax predictor ----------------

  function automatic logic is_ws(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic num_done(mode_t m);
    return m == M_NUM_ZERO || m == M_NUM_INT || m == M_NUM_FRAC || m == M_NUM_EXP;
  endfunction

  function automatic void clear_parser();
    pm = M_VALUE;
    lvl = 0;
    lpos = 0;
    hexn = 0;
    err = 1'b0;
  endfunction

  function automatic void open_level(logic is_obj);
    if (lvl >= MaxDepth) begin
      err = 1'b1;
      return;
    end
    stk[lvl] = is_obj;
    lvl++;
    pm = is_obj ? M_OBJ_FIRST : M_ARR_FIRST;
  endfunction

  function automatic void close_level();
    if (lvl > 0) lvl--;
    pm = M_AFTER;
  endfunction

  function automatic void begin_value(logic [7:0] c);
    if (is_ws(c)) return;
    if (c == "\"") pm = M_STR_VAL;
    else if (c == "{") open_level(1'b1);
    else if (c == "[") open_level(1'b0);
    else if (c == "n") begin pm = M_LIT_NULL; lpos = 1; end
    else if (c == "t") begin pm = M_LIT_TRUE; lpos = 1; end
    else if (c == "f") begin pm = M_LIT_FALSE; lpos = 1; end
    else if (c == "-") pm = M_NUM_MINUS;
    else if (c == "0") pm = M_NUM_ZERO;
    else if (c >= "1" && c <= "9") pm = M_NUM_INT;
    else err = 1'b1;
  endfunction

  function automatic void follow_value(logic [7:0] c);
    logic top;
    if (is_ws(c)) return;
    if (lvl == 0) begin
      err = 1'b1;
      return;
    end
    top = stk[lvl-1];
    if (c == ",") pm = top ? M_OBJ_KEY : M_VALUE;
    else if (c == "]" && !top) close_level();
    else if (c == "}" && top) close_level();
    else err = 1'b1;
  endfunction

  // returns 1 when the byte extends the number
  function automatic logic extend_number(logic [7:0] c);
    case (pm)
      M_NUM_MINUS: begin
        if (c == "0") begin pm = M_NUM_ZERO; return 1'b1; end
        if (c >= "1" && c <= "9") begin pm = M_NUM_INT; return 1'b1; end
        return 1'b0;
      end
      M_NUM_ZERO, M_NUM_INT: begin
        if (pm == M_NUM_INT && is_dig(c)) return 1'b1;
        if (c == ".") begin pm = M_NUM_DOT; return 1'b1; end
        if (c == "e" || c == "E") begin pm = M_NUM_E; return 1'b1; end
        return 1'b0;
      end
      M_NUM_DOT: begin
        if (is_dig(c)) begin pm = M_NUM_FRAC; return 1'b1; end
        return 1'b0;
      end
      M_NUM_FRAC: begin
        if (is_dig(c)) return 1'b1;
        if (c == "e" || c == "E") begin pm = M_NUM_E; return 1'b1; end
        return 1'b0;
      end
      M_NUM_E: begin
        if (c == "+" || c == "-") begin pm = M_NUM_ESIGN; return 1'b1; end
        if (is_dig(c)) begin pm = M_NUM_EXP; return 1'b1; end
        return 1'b0;
      end
      M_NUM_ESIGN: begin
        if (is_dig(c)) begin pm = M_NUM_EXP; return 1'b1; end
        return 1'b0;
      end
      default: return is_dig(c);
    endcase
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    string word;
    logic  key;
    key = (pm == M_STR_KEY || pm == M_ESC_KEY || pm == M_HEX_KEY);
    case (pm)
      M_VALUE: begin_value(c);
      M_ARR_FIRST: begin
        if (c == "]") close_level();
        else begin_value(c);
      end
      M_OBJ_FIRST, M_OBJ_KEY: begin
        if (!is_ws(c)) begin
          if (c == "}" && pm == M_OBJ_FIRST) close_level();
          else if (c == "\"") pm = M_STR_KEY;
          else err = 1'b1;
        end
      end
      M_COLON: begin
        if (!is_ws(c)) begin
          if (c == ":") pm = M_VALUE;
          else err = 1'b1;
        end
      end
      M_AFTER: follow_value(c);
      M_STR_VAL, M_STR_KEY: begin
        if (c == "\"") pm = key ? M_COLON : M_AFTER;
        else if (c < 8'h20) err = 1'b1;
        else if (c == "\\") pm = key ? M_ESC_KEY : M_ESC_VAL;
      end
      M_ESC_VAL, M_ESC_KEY: begin
        if (c == "\"" || c == "\\" || c == "/" || c == "b" ||
            c == "f" || c == "n" || c == "r" || c == "t") begin
          pm = key ? M_STR_KEY : M_STR_VAL;
        end else if (c == "u") begin
          hexn = 0;
          pm = key ? M_HEX_KEY : M_HEX_VAL;
        end else err = 1'b1;
      end
      M_HEX_VAL, M_HEX_KEY: begin
        if (!is_hex(c)) err = 1'b1;
        else begin
          hexn++;
          if (hexn >= 4) begin
            hexn = 0;
            pm = key ? M_STR_KEY : M_STR_VAL;
          end
        end
      end
      M_LIT_NULL, M_LIT_TRUE, M_LIT_FALSE: begin
        word = (pm == M_LIT_NULL) ? "null" : (pm == M_LIT_TRUE) ? "true" : "false";
        if (lpos >= word.len() || c != word[lpos]) err = 1'b1;
        else begin
          lpos++;
          if (lpos >= word.len()) begin
            lpos = 0;
            pm = M_AFTER;
          end
        end
      end
      default: begin
        // number: a byte that cannot extend it is handled after the value
        if (!extend_number(c)) begin
          if (!num_done(pm)) err = 1'b1;
          else begin
            pm = M_AFTER;
            follow_value(c);
          end
        end
      end
    endcase
  endfunction

  function automatic void predict_request(logic [7:0] c, logic last);
    if (!err) parse_byte(c);
    if (last) begin
      valid_expect_q.push_back(!err && lvl == 0 && (pm == M_AFTER || num_done(pm)));
      clear_parser();
    end
  endfunction

  // ---------------- document generation ----------------

  function automatic void add_doc(byte_q_t d);
    byte_req_t r;
    foreach (d[i]) begin
      r.data = d[i];
      r.last = (i == d.size() - 1);
      pending_q.push_back(r);
    end
  endfunction

  function automatic byte_q_t text_bytes(string s);
    byte_q_t d;
    for (int i = 0; i < s.len(); i++) d.push_back(s[i]);
    return d;
  endfunction

  function automatic void add_ws(ref byte_q_t d);
    logic [7:0] ws_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    if ($urandom_range(0, 3) == 0) d.push_back(ws_set[$urandom_range(0, 5)]);
  endfunction

  function automatic void gen_string(ref byte_q_t d);
    logic [7:0] esc_set[8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
    logic [7:0] hex_set[22] = '{"0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
                                "a", "b", "c", "d", "e", "f", "A", "B", "C", "D", "E", "F"};
    int n;
    int k;
    logic [7:0] c;
    d.push_back("\"");
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        d.push_back("\\");
        d.push_back(esc_set[$urandom_range(0, 7)]);
      end else if (k == 1) begin
        d.push_back("\\");
        d.push_back("u");
        for (int j = 0; j < 4; j++) d.push_back(hex_set[$urandom_range(0, 21)]);
      end else if (k == 2) begin
        d.push_back($urandom_range(8'h80, 8'hFF));
      end else begin
        c = $urandom_range(8'h20, 8'h7E);
        if (c == "\"" || c == "\\") c = "x";
        d.push_back(c);
      end
    end
    d.push_back("\"");
  endfunction

  function automatic void gen_number(ref byte_q_t d);
    if ($urandom_range(0, 2) == 0) d.push_back("-");
    if ($urandom_range(0, 3) == 0) d.push_back("0");
    else begin
      d.push_back($urandom_range("1", "9"));
      repeat ($urandom_range(0, 2)) d.push_back($urandom_range("0", "9"));
    end
    if ($urandom_range(0, 2) == 0) begin
      d.push_back(".");
      repeat ($urandom_range(1, 2)) d.push_back($urandom_range("0", "9"));
    end
    if ($urandom_range(0, 3) == 0) begin
      d.push_back($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: d.push_back("+");
        1: d.push_back("-");
        default: ;
      endcase
      d.push_back($urandom_range("0", "9"));
    end
  endfunction

  function automatic void gen_value(ref byte_q_t d, input int depth);
    int kind;
    int n;
    kind = $urandom_range(0, (depth < 3) ? 6 : 4);
    add_ws(d);
    case (kind)
      0: d = {d, text_bytes("null")};
      1: d = {d, text_bytes($urandom_range(0, 1) ? "true" : "false")};
      2: gen_number(d);
      3, 4: gen_string(d);
      5: begin
        d.push_back("[");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) d.push_back(",");
          gen_value(d, depth + 1);
        end
        add_ws(d);
        d.push_back("]");
      end
      default: begin
        d.push_back("{");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) d.push_back(",");
          add_ws(d);
          gen_string(d);
          add_ws(d);
          d.push_back(":");
          gen_value(d, depth + 1);
        end
        d.push_back("}");
      end
    endcase
    add_ws(d);
  endfunction

  function automatic void add_random_doc();
    byte_q_t d;
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      // pure noise over byte values 1 to 255
      repeat ($urandom_range(1, 8)) d.push_back($urandom_range(1, 255));
    end else begin
      gen_value(d, 0);
      if (sel <= 3) d[$urandom_range(0, d.size() - 1)] = $urandom_range(1, 255);
      else if (sel == 4 && d.size() > 1) d = d[0:$urandom_range(0, d.size() - 2)];
      else if (sel == 5) d.insert($urandom_range(0, d.size()), $urandom_range(1, 255));
    end
    add_doc(d);
  endfunction

  function automatic void build_stimulus();
    byte_q_t d;
    // directed documents
    add_doc(text_bytes("null"));
    add_doc(text_bytes(" true\t"));
    add_doc(text_bytes("false"));
    add_doc(text_bytes("nul"));
    add_doc(text_bytes("-0.5e+3"));
    add_doc(text_bytes("1."));
    add_doc(text_bytes("-"));
    add_doc(text_bytes("1e+"));
    add_doc(text_bytes("[1,2]"));
    add_doc(text_bytes("{\"k\":[],\"z\":{}}"));
    add_doc(text_bytes("{1:2}"));
    add_doc(text_bytes("1 2"));
    add_doc(text_bytes("\"\\u00aF\\n\\q\""));
    add_doc(text_bytes("[}"));
    d = text_bytes("\"a");
    d.push_back(8'h01);
    d.push_back("\"");
    add_doc(d);
    d = text_bytes("\"");
    d.push_back(8'h80);
    d.push_back(8'hFF);
    d.push_back("\"");
    add_doc(d);
    d = {};
    d.push_back(8'hFF);
    add_doc(d);
    d = {};
    d.push_back(8'h0B);
    d.push_back("0");
    d.push_back(8'h0C);
    add_doc(d);
    // nesting at the limit and one past it
    d = {};
    repeat (MaxDepth) d.push_back("[");
    repeat (MaxDepth) d.push_back("]");
    add_doc(d);
    d = {};
    repeat (MaxDepth + 1) d.push_back("[");
    repeat (MaxDepth + 1) d.push_back("]");
    add_doc(d);
    // random documents
    while (pending_q.size() < ByteTarget) add_random_doc();
  endfunction

  // ---------------- request driver ----------------

  int   src_gap;
  logic drain_hold;
  logic drained_once;

  always @(posedge clk) begin
    logic       nxt_push;
    logic [7:0] nxt_data;
    logic       nxt_last;
    logic       calm;
    nxt_push = push;
    nxt_data = in_data_byte;
    nxt_last = in_end_of_doc;
    calm = (n_accepted >= n_total - 60);
    if (!rst_n) begin
      nxt_push = 1'b0;
    end else begin
      if (push && !full) begin
        predict_request(in_data_byte, in_end_of_doc);
        n_accepted++;
        if (in_end_of_doc && n_accepted >= n_total / 2 && !drained_once) begin
          drain_hold = 1'b1;
          drained_once = 1'b1;
        end
      end
      if (!push || !full) begin
        nxt_push = 1'b0;
        if (drain_hold) begin
          // sender waits for every outstanding result
          if (valid_expect_q.size() == 0) drain_hold = 1'b0;
        end else if (src_gap > 0) begin
          src_gap--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 11) - 1;
        end else if (pending_q.size() > 0) begin
          nxt_push = 1'b1;
          nxt_data = pending_q[0].data;
          nxt_last = pending_q[0].last;
          void'(pending_q.pop_front());
        end
      end
    end
    push <= nxt_push;
    in_data_byte <= nxt_data;
    in_end_of_doc <= nxt_last;
  end

  // ---------------- result monitor ----------------

  int   sink_gap;
  int   long_hold;
  logic long_done;

  always @(posedge clk) begin
    logic nxt_pop;
    logic calm;
    calm = (n_accepted >= n_total - 60);
    nxt_pop = 1'b0;
    if (rst_n) begin
      if (pop && !empty) begin
        n_results++;
        if (valid_expect_q.size() == 0) begin
          $display("%0t: unexpected request, expected none, actual doc_valid=%0b",
                   $realtime, out_doc_valid);
          n_errors++;
        end else begin
          if (out_doc_valid !== valid_expect_q[0]) begin
            $display("%0t: doc_valid mismatch, expected %0b, actual %0b",
                     $realtime, valid_expect_q[0], out_doc_valid);
            n_errors++;
          end
          void'(valid_expect_q.pop_front());
        end
      end
      if (!long_done && n_results == 5) begin
        long_hold = 300;
        long_done = 1'b1;
      end
      if (long_hold > 0) long_hold--;
      else if (sink_gap > 0) sink_gap--;
      else if (!calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 11) - 1;
      else nxt_pop = 1'b1;
    end
    pop <= nxt_pop;
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------- run control ----------------

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_data_byte = 8'h20;
    in_end_of_doc = 1'b0;
    n_accepted = 0;
    n_results = 0;
    n_errors = 0;
    cycle_cnt = 0;
    src_gap = 0;
    sink_gap = 0;
    long_hold = 0;
    long_done = 1'b0;
    drain_hold = 1'b0;
    drained_once = 1'b0;
    clear_parser();
    build_stimulus();
    n_total = pending_q.size();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() > 0 || push || valid_expect_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (valid_expect_q.size() > 0 || !empty) n_errors++;
    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
